// ===== sv/etwl_pkg.sv =====
// Package with shared widths, codes and state encoding for the event time window linker.
`timescale 1ns / 1ps

package etwl_pkg;

	localparam int unsigned TS_W   = 40;
	localparam int unsigned ID_W   = 48;
	localparam int unsigned WIN_W  = 16;
	localparam int unsigned CFG_IW = 2;
	localparam int unsigned CFG_DW = 48;

	localparam logic [ID_W-1:0] ID_MAX = {ID_W{1'b1}};

	// Register indexes of the configuration port
	localparam logic [CFG_IW-1:0] REG_ATTACH_WINDOW = 2'd0;
	localparam logic [CFG_IW-1:0] REG_EXPIRE_WINDOW = 2'd1;
	localparam logic [CFG_IW-1:0] REG_ID_START      = 2'd2;

	// Event kinds carried in the mode field
	localparam logic MODE_ANCHOR = 1'b0;
	localparam logic MODE_FOLLOW = 1'b1;

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_EXPIRE = 6'b000010,
		ST_REUSE  = 6'b000100,
		ST_ATTACH = 6'b001000,
		ST_MARK   = 6'b010000,
		ST_DONE   = 6'b100000
	} state_t;

endpackage

// ===== sv/etwl_if.sv =====
// Valid/ready channel interfaces for event items and result items.
`timescale 1ns / 1ps

interface etwl_evt_if;
	logic                      valid;
	logic                      ready;
	logic                      mode;
	logic [etwl_pkg::TS_W-1:0] timestamp;

	modport source (output valid, output mode, output timestamp, input ready);
	modport sink (input valid, input mode, input timestamp, output ready);
endinterface

interface etwl_res_if;
	logic                      valid;
	logic                      ready;
	logic [etwl_pkg::ID_W-1:0] event_id;
	logic                      linked;

	modport source (output valid, output event_id, output linked, input ready);
	modport sink (input valid, input event_id, input linked, output ready);
endinterface

// ===== sv/etwl_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
`timescale 1ns / 1ps

module etwl_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write one entry, register the read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== sv/event_time_window_linker_top.sv =====
// Anchor/follower event linker: one shared subtractor sweeps the slot ring per item.
// Anchor: one ring write, one expiry sweep, one result load.
// Follower: a reuse sweep that stops early on a same-second reuse hit, else a reuse sweep, an attach sweep and a mark;
// the sweeps read one slot a cycle through the RAM read port. One item is in work at a time.
// Reset: ring empty (all active marks clear), head on the last slot, id counter zero,
// attach window 60, expire window 240. No clearing pass; items are taken right after reset.
`timescale 1ns / 1ps

module event_time_window_linker_top #(
	parameter int unsigned SLOTS = 128
) (
	input  logic                            clk,
	input  logic                            arst_n,
	etwl_evt_if.sink                        evt,
	etwl_res_if.source                      res,
	input  logic                            cfg_we,
	input  logic [etwl_pkg::CFG_IW-1:0]     cfg_index,
	input  logic [etwl_pkg::CFG_DW-1:0]     cfg_data
);

	localparam int unsigned IW = $clog2(SLOTS);
	localparam logic [IW-1:0] LAST = IW'(SLOTS - 1);
	localparam int unsigned TS_W = etwl_pkg::TS_W;
	localparam int unsigned ID_W = etwl_pkg::ID_W;
	localparam int unsigned WIN_W = etwl_pkg::WIN_W;

	etwl_pkg::state_t state_q;

	logic [WIN_W-1:0] attach_q;
	logic [WIN_W-1:0] expire_q;
	logic [ID_W-1:0]  id_q;
	logic [IW-1:0]    head_q;
	logic [SLOTS-1:0] active_q;
	logic [SLOTS-1:0] linked_q;

	logic [IW-1:0]    issue_q;
	logic             issue_on_q;
	logic             vld_s1;
	logic [IW-1:0]    idx_s1;

	logic             found_q;
	logic [IW-1:0]    best_q;
	logic [WIN_W-1:0] best_dt_q;
	logic [ID_W-1:0]  best_id_q;
	logic [TS_W-1:0]  ts_q;
	logic [ID_W-1:0]  res_id_q;
	logic             out_vld_q;
	logic [ID_W-1:0]  out_id_q;

	logic             evt_xfer;
	logic             anchor_xfer;
	logic [ID_W-1:0]  id_next;
	logic [IW-1:0]    head_next;

	logic [ID_W+TS_W-1:0] idt_rd;
	logic [ID_W-1:0]      rd_id;
	logic [TS_W-1:0]      rd_time;
	logic [TS_W-1:0]      rd_follow;

	logic [TS_W-1:0] sub_op;
	logic [TS_W:0]   diff;
	logic            borrow;
	logic [TS_W-1:0] mag;
	logic            expire_hit;
	logic            reuse_hit;
	logic            attach_hit;
	logic            cand_better;
	logic            mark_we;

	// Handshake
	assign evt.ready   = (state_q == etwl_pkg::ST_IDLE);
	assign evt_xfer    = evt.valid && evt.ready;
	assign anchor_xfer = evt_xfer && (evt.mode == etwl_pkg::MODE_ANCHOR);

	assign res.valid    = out_vld_q;
	assign res.event_id = out_id_q;
	assign res.linked   = (out_id_q != '0);

	// Saturating id counter and ring head advance
	assign id_next   = (id_q == etwl_pkg::ID_MAX) ? id_q : id_q + ID_W'(1);
	assign head_next = (head_q == LAST) ? '0 : head_q + IW'(1);

	// Slot storage: id and time written together by an anchor, follow time by a link
	assign mark_we = (state_q == etwl_pkg::ST_MARK) && found_q;

	etwl_ram #(
		.WIDTH (ID_W + TS_W),
		.DEPTH (SLOTS)
	) u_idt_ram (
		.clk   (clk),
		.we    (anchor_xfer),
		.waddr (head_next),
		.wdata ({id_next, evt.timestamp}),
		.raddr (issue_q),
		.rdata (idt_rd)
	);

	etwl_ram #(
		.WIDTH (TS_W),
		.DEPTH (SLOTS)
	) u_follow_ram (
		.clk   (clk),
		.we    (mark_we),
		.waddr (best_q),
		.wdata (ts_q),
		.raddr (issue_q),
		.rdata (rd_follow)
	);

	assign rd_id   = idt_rd[ID_W+TS_W-1:TS_W];
	assign rd_time = idt_rd[TS_W-1:0];

	// Shared subtractor: event time minus slot time (or follow time on the reuse pass)
	assign sub_op = (state_q == etwl_pkg::ST_REUSE) ? rd_follow : rd_time;
	assign diff   = {1'b0, ts_q} - {1'b0, sub_op};
	assign borrow = diff[TS_W];
	assign mag    = diff[TS_W-1:0];

	assign expire_hit = active_q[idx_s1] && !borrow && (mag != '0)
		&& (mag > {{(TS_W-WIN_W){1'b0}}, expire_q});
	assign reuse_hit  = active_q[idx_s1] && linked_q[idx_s1] && (diff == '0);
	assign attach_hit = active_q[idx_s1] && !borrow
		&& (mag <= {{(TS_W-WIN_W){1'b0}}, attach_q});
	assign cand_better = !found_q || (mag[WIN_W-1:0] <= best_dt_q);

	// Window registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attach_q <= WIN_W'(60);
			expire_q <= WIN_W'(240);
		end else if (cfg_we) begin
			if (cfg_index == etwl_pkg::REG_ATTACH_WINDOW) begin
				attach_q <= cfg_data[WIN_W-1:0];
			end
			if (cfg_index == etwl_pkg::REG_EXPIRE_WINDOW) begin
				expire_q <= cfg_data[WIN_W-1:0];
			end
		end
	end

	// Sequencer, slot marks, counters and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= etwl_pkg::ST_IDLE;
			id_q       <= '0;
			head_q     <= LAST;
			active_q   <= '0;
			linked_q   <= '0;
			issue_q    <= '0;
			issue_on_q <= 1'b0;
			vld_s1     <= 1'b0;
			idx_s1     <= '0;
			found_q    <= 1'b0;
			out_vld_q  <= 1'b0;
		end else begin
			// Advance the read sweep one slot a cycle
			vld_s1 <= issue_on_q;
			idx_s1 <= issue_q;
			if (issue_on_q) begin
				issue_q <= issue_q + IW'(1);
				if (issue_q == LAST) begin
					issue_on_q <= 1'b0;
					issue_q    <= '0;
				end
			end

			// Drop the result once transferred
			if (res.valid && res.ready) begin
				out_vld_q <= 1'b0;
			end

			case (state_q)
				etwl_pkg::ST_IDLE: begin
					if (cfg_we && (cfg_index == etwl_pkg::REG_ID_START)) begin
						id_q <= cfg_data[ID_W-1:0];
					end
					if (evt_xfer) begin
						issue_q    <= '0;
						issue_on_q <= 1'b1;
						if (evt.mode == etwl_pkg::MODE_ANCHOR) begin
							id_q               <= id_next;
							head_q             <= head_next;
							active_q[head_next] <= 1'b1;
							linked_q[head_next] <= 1'b0;
							state_q            <= etwl_pkg::ST_EXPIRE;
						end else begin
							found_q <= 1'b0;
							state_q <= etwl_pkg::ST_REUSE;
						end
					end
				end
				etwl_pkg::ST_EXPIRE: begin
					if (vld_s1 && expire_hit) begin
						active_q[idx_s1] <= 1'b0;
					end
					if (vld_s1 && (idx_s1 == LAST)) begin
						state_q <= etwl_pkg::ST_DONE;
					end
				end
				etwl_pkg::ST_REUSE: begin
					if (vld_s1 && reuse_hit) begin
						issue_on_q <= 1'b0;
						issue_q    <= '0;
						vld_s1     <= 1'b0;
						state_q    <= etwl_pkg::ST_DONE;
					end else if (vld_s1 && (idx_s1 == LAST)) begin
						issue_q    <= '0;
						issue_on_q <= 1'b1;
						vld_s1     <= 1'b0;
						state_q    <= etwl_pkg::ST_ATTACH;
					end
				end
				etwl_pkg::ST_ATTACH: begin
					if (vld_s1 && attach_hit && cand_better) begin
						found_q <= 1'b1;
					end
					if (vld_s1 && (idx_s1 == LAST)) begin
						state_q <= etwl_pkg::ST_MARK;
					end
				end
				etwl_pkg::ST_MARK: begin
					if (found_q) begin
						linked_q[best_q] <= 1'b1;
					end
					state_q <= etwl_pkg::ST_DONE;
				end
				etwl_pkg::ST_DONE: begin
					if (!out_vld_q || res.ready) begin
						out_vld_q <= 1'b1;
						state_q   <= etwl_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= etwl_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (evt_xfer) begin
			ts_q <= evt.timestamp;
			if (evt.mode == etwl_pkg::MODE_ANCHOR) begin
				res_id_q <= id_next;
			end
		end
		if ((state_q == etwl_pkg::ST_REUSE) && vld_s1 && reuse_hit) begin
			res_id_q <= rd_id;
		end
		if ((state_q == etwl_pkg::ST_ATTACH) && vld_s1 && attach_hit && cand_better) begin
			best_q    <= idx_s1;
			best_dt_q <= mag[WIN_W-1:0];
			best_id_q <= rd_id;
		end
		if (state_q == etwl_pkg::ST_MARK) begin
			res_id_q <= found_q ? best_id_q : '0;
		end
		if ((state_q == etwl_pkg::ST_DONE) && (!out_vld_q || res.ready)) begin
			out_id_q <= res_id_q;
		end
	end

endmodule

// ===== dv/event_time_window_linker_top_tb.sv =====
// Self-checking testbench for the event time window linker: driver, monitor and slot-ring predictor.
`timescale 1ns / 1ps

module event_time_window_linker_top_tb;

	localparam int unsigned TS_W            = etwl_pkg::TS_W;
	localparam int unsigned ID_W            = etwl_pkg::ID_W;
	localparam int unsigned WIN_W           = etwl_pkg::WIN_W;
	localparam int unsigned CFG_IW          = etwl_pkg::CFG_IW;
	localparam int unsigned CFG_DW          = etwl_pkg::CFG_DW;
	localparam logic [ID_W-1:0] ID_MAX      = etwl_pkg::ID_MAX;
	localparam int unsigned SLOTS           = 128;
	localparam int unsigned DEFAULT_ATTACH  = 60;
	localparam int unsigned EXPIRE_FACTOR   = 4;
	localparam int unsigned PHASE_ITEMS     = 220;
	localparam int unsigned PRESSURE_AT     = 150;
	localparam int unsigned PRESSURE_CYCLES = 2000;
	localparam logic [CFG_IW-1:0] REG_UNUSED = 2'd3;
	localparam logic [TS_W-1:0]   TS_MAX     = {TS_W{1'b1}};

	typedef struct packed {
		logic            mode;
		logic [TS_W-1:0] ts;
	} evt_item_t;

	typedef struct packed {
		logic [ID_W-1:0] event_id;
		logic            linked;
	} link_result_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_we;
	logic [CFG_IW-1:0] cfg_index;
	logic [CFG_DW-1:0] cfg_data;

	etwl_evt_if evt ();
	etwl_res_if res ();

	event_time_window_linker_top #(
		.SLOTS(SLOTS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.evt      (evt),
		.res      (res),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	// Predicted slot ring and registers
	logic [ID_W-1:0]  ring_id     [SLOTS];
	logic [TS_W-1:0]  ring_time   [SLOTS];
	logic [TS_W-1:0]  ring_follow [SLOTS];
	bit               ring_linked [SLOTS];
	bit               ring_active [SLOTS];
	int unsigned      ring_head;
	logic [ID_W-1:0]  next_id;
	logic [WIN_W-1:0] attach_win;
	logic [WIN_W-1:0] expire_win;

	evt_item_t    evt_pending[$];
	link_result_t link_expected[$];
	evt_item_t    drv_item;
	link_result_t want;

	int unsigned evt_offered = 0;
	int unsigned evt_accepted = 0;
	int unsigned res_count = 0;
	int unsigned gap_left = 0;
	int unsigned hold_left = 0;
	int unsigned ready_roll;
	bit          pressure_done = 1'b0;
	int unsigned fail_count = 0;

	logic [TS_W-1:0] stream_ts = '0;
	logic [TS_W-1:0] last_follow_ts = '0;

	always #5 clk = ~clk;

	// Compute the result of one event and update the predicted ring
	function automatic link_result_t predict_link(input logic mode, input logic [TS_W-1:0] ts);
		link_result_t    r;
		bit              found;
		bit              reused;
		int unsigned     best;
		logic [TS_W-1:0] dt;
		logic [TS_W-1:0] best_dt;
		r.event_id = '0;
		found = 1'b0;
		reused = 1'b0;
		best = 0;
		best_dt = '0;
		if (mode == etwl_pkg::MODE_ANCHOR) begin
			if (next_id != ID_MAX)
				next_id = next_id + ID_W'(1);
			ring_head = (ring_head + 1 >= SLOTS) ? 0 : ring_head + 1;
			ring_id[ring_head] = next_id;
			ring_time[ring_head] = ts;
			ring_follow[ring_head] = '0;
			ring_linked[ring_head] = 1'b0;
			ring_active[ring_head] = 1'b1;
			// Drop anchors older than the expiry window; future anchors stay
			for (int i = 0; i < SLOTS; i++) begin
				if (ring_active[i] && ts > ring_time[i] &&
					(ts - ring_time[i]) > {{(TS_W-WIN_W){1'b0}}, expire_win})
					ring_active[i] = 1'b0;
			end
			r.event_id = next_id;
		end else begin
			// Reuse the lowest slot already linked at this very second
			for (int i = 0; i < SLOTS; i++) begin
				if (!reused && ring_active[i] && ring_linked[i] && ring_follow[i] == ts) begin
					reused = 1'b1;
					r.event_id = ring_id[i];
				end
			end
			if (!reused) begin
				// Nearest past anchor within the window; ties go to the higher index
				for (int i = 0; i < SLOTS; i++) begin
					if (ring_active[i] && ring_time[i] <= ts) begin
						dt = ts - ring_time[i];
						if (dt <= {{(TS_W-WIN_W){1'b0}}, attach_win} && (!found || dt <= best_dt)) begin
							found = 1'b1;
							best = i;
							best_dt = dt;
						end
					end
				end
				if (found) begin
					ring_follow[best] = ts;
					ring_linked[best] = 1'b1;
					r.event_id = ring_id[best];
				end
			end
		end
		r.linked = (r.event_id != '0);
		return r;
	endfunction

	function automatic logic [CFG_DW-1:0] rand_wide();
		logic [63:0] w;
		w = {$urandom(), $urandom()};
		return w[CFG_DW-1:0];
	endfunction

	function automatic int unsigned draw_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 88)
			return $urandom_range(1, 3);
		else if (r < 98)
			return $urandom_range(4, 25);
		else
			return $urandom_range(60, 300);
	endfunction

	// Write one register at an idle point and mirror it in the predictor
	task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		case (idx)
			etwl_pkg::REG_ATTACH_WINDOW: attach_win = data[WIN_W-1:0];
			etwl_pkg::REG_EXPIRE_WINDOW: expire_win = data[WIN_W-1:0];
			etwl_pkg::REG_ID_START:      next_id = data[ID_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Fill the upper data bits with noise; only the low bits land in a window
	task automatic write_window(input logic [CFG_IW-1:0] idx, input logic [WIN_W-1:0] value);
		logic [CFG_DW-1:0] d;
		d = rand_wide();
		d[WIN_W-1:0] = value;
		write_reg(idx, d);
	endtask

	task automatic push_evt(input logic mode, input logic [TS_W-1:0] ts);
		evt_item_t it;
		it.mode = mode;
		it.ts = ts;
		evt_pending.push_back(it);
	endtask

	// Queue a stream of anchors and followers around a moving time base
	task automatic push_random(input int unsigned n);
		int unsigned     r;
		int unsigned     r2;
		logic [63:0]     w;
		logic [TS_W-1:0] ts;
		for (int k = 0; k < n; k++) begin
			r = $urandom_range(0, 99);
			if (r < 3) begin
				w = {$urandom(), $urandom()};
				stream_ts = w[TS_W-1:0];
			end else if (r < 5) begin
				stream_ts = TS_MAX - TS_W'($urandom_range(0, 2000));
			end
			r = $urandom_range(0, 99);
			r2 = $urandom_range(0, 99);
			if (r < 5) begin
				w = {$urandom(), $urandom()};
				push_evt(1'($urandom_range(0, 1)), w[TS_W-1:0]);
			end else if (r < 50) begin
				// Hold the second for a tie, jump far for expiry, else step a little
				if (r2 >= 18)
					stream_ts = stream_ts + TS_W'($urandom_range(0, 40));
				else if (r2 >= 12)
					stream_ts = stream_ts + TS_W'($urandom_range(200, 600));
				push_evt(etwl_pkg::MODE_ANCHOR, stream_ts);
			end else begin
				if (r2 < 30)
					ts = last_follow_ts;
				else if (r2 < 85)
					ts = stream_ts + TS_W'($urandom_range(0, 90));
				else
					ts = stream_ts - TS_W'($urandom_range(0, 120));
				last_follow_ts = ts;
				push_evt(etwl_pkg::MODE_FOLLOW, ts);
			end
		end
	endtask

	// Block until every queued event is taken and every result has come back
	task automatic wait_idle();
		do
			@(posedge clk);
		while (evt_pending.size() != 0 || evt.valid || link_expected.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	// Event driver: present the next pending item once the last one is transferred
	always @(negedge clk) begin
		if (!arst_n) begin
			evt.valid <= 1'b0;
		end else if (!evt.valid || evt_accepted == evt_offered) begin
			if (gap_left != 0) begin
				evt.valid <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (evt_pending.size() != 0) begin
				drv_item = evt_pending.pop_front();
				evt.valid <= 1'b1;
				evt.mode <= drv_item.mode;
				evt.timestamp <= drv_item.ts;
				evt_offered <= evt_offered + 1;
				gap_left <= draw_gap();
			end else begin
				evt.valid <= 1'b0;
			end
		end
	end

	// Result sink: random back-pressure plus one long hold-off to fill the block
	always @(negedge clk) begin
		if (!arst_n) begin
			res.ready <= 1'b0;
		end else if (hold_left != 0) begin
			res.ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (!pressure_done && res_count >= PRESSURE_AT) begin
			pressure_done <= 1'b1;
			hold_left <= PRESSURE_CYCLES;
			res.ready <= 1'b0;
		end else begin
			ready_roll = $urandom_range(0, 999);
			if (ready_roll < 2) begin
				hold_left <= $urandom_range(50, 400);
				res.ready <= 1'b0;
			end else if (ready_roll < 32) begin
				hold_left <= $urandom_range(1, 20);
				res.ready <= 1'b0;
			end else begin
				res.ready <= 1'b1;
			end
		end
	end

	// Monitor: check each result transfer, then predict each event transfer
	always @(posedge clk) begin
		if (arst_n) begin
			if (res.valid && res.ready) begin
				res_count <= res_count + 1;
				if (link_expected.size() == 0) begin
					$error("unexpected result: event_id %0h linked %0b", res.event_id, res.linked);
					fail_count++;
				end else begin
					want = link_expected.pop_front();
					if (res.event_id !== want.event_id) begin
						$error("event_id mismatch: expected %0h actual %0h",
							want.event_id, res.event_id);
						fail_count++;
					end
					if (res.linked !== want.linked) begin
						$error("linked mismatch: expected %0b actual %0b", want.linked, res.linked);
						fail_count++;
					end
				end
			end
			if (evt.valid && evt.ready) begin
				link_expected.push_back(predict_link(evt.mode, evt.timestamp));
				evt_accepted <= evt_accepted + 1;
			end
		end
	end

	initial begin
		evt.valid = 1'b0;
		evt.mode = etwl_pkg::MODE_ANCHOR;
		evt.timestamp = '0;
		res.ready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = etwl_pkg::REG_ATTACH_WINDOW;
		cfg_data = '0;
		for (int i = 0; i < SLOTS; i++) begin
			ring_id[i] = '0;
			ring_time[i] = '0;
			ring_follow[i] = '0;
			ring_linked[i] = 1'b0;
			ring_active[i] = 1'b0;
		end
		ring_head = SLOTS - 1;
		next_id = '0;
		attach_win = WIN_W'(DEFAULT_ATTACH);
		expire_win = WIN_W'(DEFAULT_ATTACH * EXPIRE_FACTOR);

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: empty ring, exact window edges, ties, reuse, expiry, future anchors
		push_evt(etwl_pkg::MODE_FOLLOW, '0);
		push_evt(etwl_pkg::MODE_ANCHOR, '0);
		push_evt(etwl_pkg::MODE_FOLLOW, '0);
		push_evt(etwl_pkg::MODE_FOLLOW, '0);
		push_evt(etwl_pkg::MODE_ANCHOR, '0);
		push_evt(etwl_pkg::MODE_FOLLOW, 40'd1);
		push_evt(etwl_pkg::MODE_FOLLOW, 40'd60);
		push_evt(etwl_pkg::MODE_FOLLOW, 40'd121);
		push_evt(etwl_pkg::MODE_ANCHOR, 40'd241);
		push_evt(etwl_pkg::MODE_FOLLOW, 40'd241);
		push_evt(etwl_pkg::MODE_FOLLOW, 40'd240);
		push_evt(etwl_pkg::MODE_ANCHOR, 40'd100);
		push_evt(etwl_pkg::MODE_FOLLOW, 40'd241);
		push_evt(etwl_pkg::MODE_FOLLOW, 40'd160);
		push_evt(etwl_pkg::MODE_ANCHOR, TS_MAX);
		push_evt(etwl_pkg::MODE_FOLLOW, TS_MAX);
		push_evt(etwl_pkg::MODE_FOLLOW, TS_MAX - TS_W'(DEFAULT_ATTACH));
		push_evt(etwl_pkg::MODE_FOLLOW, TS_MAX);
		push_evt(etwl_pkg::MODE_FOLLOW, '0);
		push_random(PHASE_ITEMS);
		wait_idle();

		// Zero windows: only same-second links, every new anchor expires all older anchors
		write_window(etwl_pkg::REG_ATTACH_WINDOW, '0);
		write_window(etwl_pkg::REG_EXPIRE_WINDOW, '0);
		write_reg(etwl_pkg::REG_ID_START, '0);
		write_reg(REG_UNUSED, rand_wide());
		push_random(PHASE_ITEMS);
		wait_idle();

		// Widest windows and a counter close to saturation
		write_window(etwl_pkg::REG_ATTACH_WINDOW, {WIN_W{1'b1}});
		write_window(etwl_pkg::REG_EXPIRE_WINDOW, {WIN_W{1'b1}});
		write_reg(etwl_pkg::REG_ID_START, ID_MAX - 3);
		push_random(PHASE_ITEMS);
		wait_idle();

		// Random windows and a random id base
		write_window(etwl_pkg::REG_ATTACH_WINDOW, WIN_W'($urandom_range(1, 200)));
		write_window(etwl_pkg::REG_EXPIRE_WINDOW, WIN_W'($urandom_range(0, 1000)));
		write_reg(etwl_pkg::REG_ID_START, rand_wide());
		write_reg(REG_UNUSED, rand_wide());
		push_random(PHASE_ITEMS);
		wait_idle();

		// Saturated counter: every anchor shares one id
		write_window(etwl_pkg::REG_ATTACH_WINDOW, WIN_W'(DEFAULT_ATTACH / 2));
		write_window(etwl_pkg::REG_EXPIRE_WINDOW, WIN_W'(DEFAULT_ATTACH * 3 / 2));
		write_reg(etwl_pkg::REG_ID_START, ID_MAX);
		push_random(PHASE_ITEMS);
		wait_idle();

		// Catch any late or extra result
		repeat (2 * SLOTS + 8) @(posedge clk);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#50_000_000;
		$display("Test completed with failures");
		$finish;
	end

endmodule
